### src/rdw_pkg.sv
// shared types and constants for the relay duty and window scheduler
package rdw_pkg;

	localparam int CHANNELS   = 4;
	localparam int CH_W       = 2;
	localparam int LANE_W     = 4;
	localparam int MODE_W     = 2;
	localparam int PCT_W      = 7;
	localparam int PERIOD_W   = 16;
	localparam int WIN_W      = 32;
	localparam int MS_W       = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int PROD_W     = PCT_W + PERIOD_W;
	localparam int THR_W      = PROD_W + 4;

	localparam logic [PCT_W-1:0]    PCT_FULL    = 7'd100;
	localparam logic [PERIOD_W-1:0] MIN_PERIOD  = 16'd2;
	localparam logic [MS_W-1:0]     PHASE_RESET = 32'd86400;

	typedef logic [MODE_W-1:0] ctl_mode_t;
	localparam ctl_mode_t CTL_DUTY   = 2'd1;
	localparam ctl_mode_t CTL_WINDOW = 2'd2;

	localparam logic ITEM_TICK   = 1'b0;
	localparam logic ITEM_MANUAL = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ON_LEVEL   = 3'd0,
		REG_MODES      = 3'd1,
		REG_PERCENTS   = 3'd2,
		REG_PERIODS    = 3'd3,
		REG_WSTART_LO  = 3'd4,
		REG_WSTART_HI  = 3'd5,
		REG_WLEN_LO    = 3'd6,
		REG_WLEN_HI    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		ctl_mode_t             mode;
		logic [PCT_W-1:0]      pct;
		logic [PERIOD_W-1:0]   period;
		logic [WIN_W-1:0]      win_start;
		logic [WIN_W-1:0]      win_len;
	} chan_cfg_t;

	typedef struct packed {
		logic toggle;
		logic restart;
	} chan_upd_t;

	typedef struct packed {
		logic              mode;
		logic [CH_W-1:0]   channel;
		logic              turn_on;
		logic [MS_W-1:0]   now_ms;
		logic [WIN_W-1:0]  epoch_s;
	} item_t;

endpackage

### src/rdw_item_if.sv
// item channel: tick or manual command beats
interface rdw_item_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [1:0]  channel;
	logic        turn_on;
	logic [31:0] now_ms;
	logic [31:0] epoch_s;

	modport source (output valid, mode, channel, turn_on, now_ms, epoch_s, input ready);
	modport sink (input valid, mode, channel, turn_on, now_ms, epoch_s, output ready);
endinterface

### src/rdw_result_if.sv
// result channel: drive levels and switch mask
interface rdw_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] relay_drive;
	logic [3:0] changed_mask;

	modport source (output valid, relay_drive, changed_mask, input ready);
	modport sink (input valid, relay_drive, changed_mask, output ready);
endinterface

### src/rdw_cfg_if.sv
// configuration write channel
interface rdw_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/rdw_cfg_regs.sv
// configuration register file and per-channel field unpacking
module rdw_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	rdw_cfg_if.sink             cfg,
	output logic                on_level,
	output rdw_pkg::chan_cfg_t  chan_cfg [rdw_pkg::CHANNELS]
);
	import rdw_pkg::*;

	logic                  on_level_q;
	logic [7:0]            modes_q;
	logic [27:0]           percents_q;
	logic [63:0]           periods_q;
	logic [63:0]           wstart_lo_q;
	logic [63:0]           wstart_hi_q;
	logic [63:0]           wlen_lo_q;
	logic [63:0]           wlen_hi_q;

	assign cfg.ready = 1'b1;
	assign on_level  = on_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_level_q  <= 1'b1;
			modes_q     <= '0;
			percents_q  <= '0;
			periods_q   <= '0;
			wstart_lo_q <= '0;
			wstart_hi_q <= '0;
			wlen_lo_q   <= '0;
			wlen_hi_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_ON_LEVEL:  on_level_q  <= cfg.data[0];
				REG_MODES:     modes_q     <= cfg.data[7:0];
				REG_PERCENTS:  percents_q  <= cfg.data[27:0];
				REG_PERIODS:   periods_q   <= cfg.data;
				REG_WSTART_LO: wstart_lo_q <= cfg.data;
				REG_WSTART_HI: wstart_hi_q <= cfg.data;
				REG_WLEN_LO:   wlen_lo_q   <= cfg.data;
				REG_WLEN_HI:   wlen_hi_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// even channel in the low word, odd channel in the high word
	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		assign chan_cfg[c].mode   = modes_q[MODE_W*c +: MODE_W];
		assign chan_cfg[c].pct    = percents_q[PCT_W*c +: PCT_W];
		assign chan_cfg[c].period = periods_q[PERIOD_W*c +: PERIOD_W];
		assign chan_cfg[c].win_start = (c < 2) ? wstart_lo_q[WIN_W*(c%2) +: WIN_W]
		                                       : wstart_hi_q[WIN_W*(c%2) +: WIN_W];
		assign chan_cfg[c].win_len   = (c < 2) ? wlen_lo_q[WIN_W*(c%2) +: WIN_W]
		                                       : wlen_hi_q[WIN_W*(c%2) +: WIN_W];
	end

endmodule

### src/rdw_chan.sv
// per-channel tick decision: duty phase timing and date window test
module rdw_chan (
	input  rdw_pkg::chan_cfg_t        ccfg,
	input  logic                      relay_on,
	input  logic [rdw_pkg::MS_W-1:0]  phase_ms,
	input  logic [rdw_pkg::MS_W-1:0]  now_ms,
	input  logic [rdw_pkg::WIN_W-1:0] epoch_s,
	output rdw_pkg::chan_upd_t        upd
);
	import rdw_pkg::*;

	logic [PCT_W-1:0]    pct_sat;
	logic [PERIOD_W-1:0] per_sat;
	logic [PCT_W-1:0]    factor;
	logic [PROD_W-1:0]   prod;
	logic [THR_W-1:0]    thr;
	logic [MS_W-1:0]     elapsed;
	logic                hit;
	logic                duty_sw;
	logic [WIN_W:0]      win_end;
	logic                target;
	logic                win_sw;

	always_comb begin
		pct_sat = (ccfg.pct > PCT_FULL) ? PCT_FULL : ccfg.pct;
		per_sat = (ccfg.period < MIN_PERIOD) ? MIN_PERIOD : ccfg.period;
		// on phase length while energized, off phase length while released
		factor  = relay_on ? pct_sat : PCT_FULL - pct_sat;
		prod    = PROD_W'(factor) * PROD_W'(per_sat);
		// x10 ms per percent-second
		thr     = (THR_W'(prod) << 3) + (THR_W'(prod) << 1);
		elapsed = now_ms - phase_ms;
		hit     = elapsed >= MS_W'(thr);
		duty_sw = (ccfg.pct != '0) && (relay_on ? (pct_sat != PCT_FULL) && hit : hit);

		win_end = {1'b0, ccfg.win_start} + {1'b0, ccfg.win_len};
		target  = (epoch_s >= ccfg.win_start) && ({1'b0, epoch_s} < win_end);
		win_sw  = (ccfg.win_len != '0) && (target != relay_on);

		upd = '0;
		unique case (ccfg.mode)
			CTL_DUTY: begin
				upd.toggle  = duty_sw;
				upd.restart = duty_sw;
			end
			CTL_WINDOW: begin
				upd.toggle = win_sw;
			end
			default: ;
		endcase
	end

endmodule

### src/relay_duty_and_window_scheduler.sv
// top level: four-channel relay timer with duty-cycle and date-window modes
// Takes one item per cycle while the output is not stalled, using a two-stage path: the item
// beat is captured in an input register, all channels are evaluated in parallel (one 7x16
// multiply and a 32-bit compare per channel) and the drive levels land in an output register;
// a new item can be taken every cycle while the result register is free or being drained, and
// relay state and duty phase timestamps update as the result is registered, so the next item
// always sees them. A manual command always flags its channel in changed_mask; a tick flags
// each channel that switched. Config writes are taken every cycle and must happen only while
// no item is in flight.
module relay_duty_and_window_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	rdw_item_if.sink    items,
	rdw_result_if.source results,
	rdw_cfg_if.sink     cfg
);
	import rdw_pkg::*;

	logic                on_level;
	chan_cfg_t           chan_cfg [CHANNELS];
	chan_upd_t           upd [CHANNELS];

	item_t               item_s1;
	logic                valid_s1;
	logic                valid_s2;
	logic [LANE_W-1:0]   drive_s2;
	logic [LANE_W-1:0]   changed_s2;

	logic [CHANNELS-1:0] relay_on_q;
	logic [MS_W-1:0]     phase_q [CHANNELS];

	logic                advance;
	logic                fire;
	logic [CHANNELS-1:0] next_on;
	logic [CHANNELS-1:0] changed;
	logic [CHANNELS-1:0] drive;

	rdw_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.on_level (on_level),
		.chan_cfg (chan_cfg)
	);

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		rdw_chan u_chan (
			.ccfg     (chan_cfg[c]),
			.relay_on (relay_on_q[c]),
			.phase_ms (phase_q[c]),
			.now_ms   (item_s1.now_ms),
			.epoch_s  (item_s1.epoch_s),
			.upd      (upd[c])
		);
	end

	assign advance     = !valid_s2 || results.ready;
	assign fire        = valid_s1 && advance;
	assign items.ready = !valid_s1 || advance;

	always_comb begin
		next_on = relay_on_q;
		changed = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (item_s1.mode == ITEM_MANUAL) begin
				if (item_s1.channel == CH_W'(c)) begin
					next_on[c] = item_s1.turn_on;
					changed[c] = 1'b1;
				end
			end else if (upd[c].toggle) begin
				next_on[c] = !relay_on_q[c];
				changed[c] = 1'b1;
			end
		end
		drive = on_level ? next_on : ~next_on;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			relay_on_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				phase_q[c] <= PHASE_RESET;
			end
		end else begin
			if (items.ready) begin
				valid_s1 <= items.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				relay_on_q <= next_on;
				if (item_s1.mode == ITEM_TICK) begin
					for (int c = 0; c < CHANNELS; c++) begin
						if (upd[c].restart) begin
							phase_q[c] <= item_s1.now_ms;
						end
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.mode    <= items.mode;
			item_s1.channel <= items.channel;
			item_s1.turn_on <= items.turn_on;
			item_s1.now_ms  <= items.now_ms;
			item_s1.epoch_s <= items.epoch_s;
		end
		if (fire) begin
			drive_s2   <= LANE_W'(drive);
			changed_s2 <= LANE_W'(changed);
		end
	end

	assign results.valid        = valid_s2;
	assign results.relay_drive  = drive_s2;
	assign results.changed_mask = changed_s2;

endmodule

### src/rdw_checker.sv
// port-level checks for the relay scheduler, bound to the top level
module rdw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [3:0] res_drive,
	input logic [3:0] res_changed
);

	// a stalled result beat holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_drive) && $stable(res_changed))
		else $error("result beat dropped or changed while stalled");

	// every accepted item leads to a pending result once it has passed the input and output registers
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 res_valid)
		else $error("accepted item produced no pending result");

	// input backpressure only comes from a stalled output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> res_valid && !res_ready)
		else $error("input stalled without output backpressure");

endmodule

bind relay_duty_and_window_scheduler rdw_checker u_rdw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (items.valid),
	.in_ready    (items.ready),
	.res_valid   (results.valid),
	.res_ready   (results.ready),
	.res_drive   (results.relay_drive),
	.res_changed (results.changed_mask)
);
